@@ src/mlfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared constants, status codes and controller/datapath types of the
// three-level feedback-queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam int NUM_TASKS_DEF  = 16;
   localparam int MAX_BURSTS_DEF = 32;
   localparam int BURST_BITS_DEF = 10;

   localparam int TASK_ID_W  = 4;
   localparam int LEN_W      = 10;
   localparam int CNT_W      = 20;
   localparam int SLICE_W    = 6;
   localparam int LEVEL_W    = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]   CNT_SAT      = '1;
   localparam logic [SLICE_W-1:0] L1_LIMIT_RST = 6'd7;
   localparam logic [SLICE_W-1:0] L2_LIMIT_RST = 6'd11;

   localparam logic [STATUS_W-1:0] ST_UNLOADED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_READY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RUN      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IO       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_L1 = 1'b0;
   localparam logic CSR_IDX_L2 = 1'b1;

   // command from the controller to the datapath
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_ACCEPT,
      OP_LD_RD,
      OP_LD_WR,
      OP_DP_POP,
      OP_DP_RD,
      OP_DP_WR,
      OP_SW_RD,
      OP_SW_UP,
      OP_SW_IO,
      OP_RN_RD,
      OP_RN_UP,
      OP_RN_IO,
      OP_FIN
   } op_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic cur_valid;
      logic any_queued;
      logic need_burst;
      logic out_free;
   } dp_status_type;

endpackage

@@ src/mlfq_if.sv @@
// ----------------------------------------------------------------------------
// mlfq request / response channels
// Valid/ready channels carrying one load or tick item and one tick result.
// ----------------------------------------------------------------------------
interface mlfq_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [mlfq_pkg::TASK_ID_W-1:0] task_id;
   logic [mlfq_pkg::LEN_W-1:0]     burst_length;
   logic                           last_burst;

   modport source (output valid, action, task_id, burst_length, last_burst, input ready);
   modport sink   (input valid, action, task_id, burst_length, last_burst, output ready);
endinterface

interface mlfq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mlfq_pkg::TASK_ID_W-1:0] running_task;
   logic                           cpu_idle;
   logic                           finished_valid;
   logic [mlfq_pkg::TASK_ID_W-1:0] finished_task;
   logic [mlfq_pkg::CNT_W-1:0]     finished_wait;
   logic [mlfq_pkg::CNT_W-1:0]     finished_turnaround;
   logic [mlfq_pkg::CNT_W-1:0]     finished_response;
   logic [mlfq_pkg::CNT_W-1:0]     elapsed_ticks;
   logic [mlfq_pkg::CNT_W-1:0]     busy_ticks;
   logic                           all_done;

   modport source (output valid, running_task, cpu_idle, finished_valid, finished_task,
                   finished_wait, finished_turnaround, finished_response,
                   elapsed_ticks, busy_ticks, all_done, input ready);
   modport sink   (input valid, running_task, cpu_idle, finished_valid, finished_task,
                   finished_wait, finished_turnaround, finished_response,
                   elapsed_ticks, busy_ticks, all_done, output ready);
endinterface

@@ src/mlfq_csr.sv @@
// ----------------------------------------------------------------------------
// mlfq_csr
// APB-style register file holding the two slice limits.
// ----------------------------------------------------------------------------
module mlfq_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mlfq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mlfq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [mlfq_pkg::SLICE_W-1:0]     l1_limit,
   output logic [mlfq_pkg::SLICE_W-1:0]     l2_limit
);

   logic [mlfq_pkg::SLICE_W-1:0] l1_ff, l2_ff;
   logic                         wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign l1_limit   = l1_ff;
   assign l2_limit   = l2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff <= mlfq_pkg::L1_LIMIT_RST;
         l2_ff <= mlfq_pkg::L2_LIMIT_RST;
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            mlfq_pkg::CSR_IDX_L1: l1_ff <= csr_pwdata[mlfq_pkg::SLICE_W-1:0];
            mlfq_pkg::CSR_IDX_L2: l2_ff <= csr_pwdata[mlfq_pkg::SLICE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mlfq_pkg::CSR_IDX_L1: csr_prdata = mlfq_pkg::CSR_DATA_W'(l1_ff);
         mlfq_pkg::CSR_IDX_L2: csr_prdata = mlfq_pkg::CSR_DATA_W'(l2_ff);
         default:              csr_prdata = '0;
      endcase
   end

endmodule

@@ src/mlfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: load, dispatch, per-task sweep, running-task update, result.
// ----------------------------------------------------------------------------
module mlfq_ctrl #(
   parameter int NUM_TASKS = mlfq_pkg::NUM_TASKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_action,
   output logic                            req_ready,
   input  mlfq_pkg::dp_status_type         status,
   output mlfq_pkg::op_type                op,
   output logic [$clog2(NUM_TASKS)-1:0]    sweep_idx
);

   localparam int IDW = $clog2(NUM_TASKS);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LD_RD  = 4'd1;
   localparam logic [3:0] S_LD_WR  = 4'd2;
   localparam logic [3:0] S_DP_POP = 4'd3;
   localparam logic [3:0] S_DP_RD  = 4'd4;
   localparam logic [3:0] S_DP_WR  = 4'd5;
   localparam logic [3:0] S_SW_RD  = 4'd6;
   localparam logic [3:0] S_SW_UP  = 4'd7;
   localparam logic [3:0] S_SW_IO  = 4'd8;
   localparam logic [3:0] S_RN_RD  = 4'd9;
   localparam logic [3:0] S_RN_UP  = 4'd10;
   localparam logic [3:0] S_RN_IO  = 4'd11;
   localparam logic [3:0] S_FIN    = 4'd12;

   logic [3:0]     state_ff, state_in;
   logic [IDW-1:0] idx_ff, idx_in;
   logic [3:0]     after_sweep;
   logic           idx_last;

   assign req_ready   = (state_ff == S_IDLE);
   assign sweep_idx   = idx_ff;
   assign idx_last    = (idx_ff == IDW'(NUM_TASKS - 1));
   assign after_sweep = status.cur_valid ? S_RN_RD : S_FIN;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      op       = mlfq_pkg::OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op     = mlfq_pkg::OP_ACCEPT;
               idx_in = '0;
               if (!req_action) state_in = S_LD_RD;
               else if (!status.cur_valid) state_in = S_DP_POP;
               else state_in = S_SW_RD;
            end
         end
         S_LD_RD: begin
            op       = mlfq_pkg::OP_LD_RD;
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            op       = mlfq_pkg::OP_LD_WR;
            state_in = S_IDLE;
         end
         S_DP_POP: begin
            op       = mlfq_pkg::OP_DP_POP;
            state_in = status.any_queued ? S_DP_RD : S_SW_RD;
         end
         S_DP_RD: begin
            op       = mlfq_pkg::OP_DP_RD;
            state_in = S_DP_WR;
         end
         S_DP_WR: begin
            op       = mlfq_pkg::OP_DP_WR;
            state_in = S_SW_RD;
         end
         S_SW_RD: begin
            op       = mlfq_pkg::OP_SW_RD;
            state_in = S_SW_UP;
         end
         S_SW_UP: begin
            op = mlfq_pkg::OP_SW_UP;
            if (status.need_burst) state_in = S_SW_IO;
            else if (idx_last) state_in = after_sweep;
            else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SW_RD;
            end
         end
         S_SW_IO: begin
            op = mlfq_pkg::OP_SW_IO;
            if (idx_last) state_in = after_sweep;
            else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SW_RD;
            end
         end
         S_RN_RD: begin
            op       = mlfq_pkg::OP_RN_RD;
            state_in = S_RN_UP;
         end
         S_RN_UP: begin
            op       = mlfq_pkg::OP_RN_UP;
            state_in = status.need_burst ? S_RN_IO : S_FIN;
         end
         S_RN_IO: begin
            op       = mlfq_pkg::OP_RN_IO;
            state_in = S_FIN;
         end
         S_FIN: begin
            op = mlfq_pkg::OP_FIN;
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

@@ src/mlfq_dp.sv @@
// ----------------------------------------------------------------------------
// mlfq_dp
// Datapath: task records, burst store, level queues, totals, result register.
// ----------------------------------------------------------------------------
module mlfq_dp #(
   parameter int NUM_TASKS  = mlfq_pkg::NUM_TASKS_DEF,
   parameter int MAX_BURSTS = mlfq_pkg::MAX_BURSTS_DEF,
   parameter int BURST_BITS = mlfq_pkg::BURST_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mlfq_pkg::op_type                  op,
   input  logic [$clog2(NUM_TASKS)-1:0]      sweep_idx,
   input  logic                              req_action,
   input  logic [mlfq_pkg::TASK_ID_W-1:0]    req_task_id,
   input  logic [mlfq_pkg::LEN_W-1:0]        req_burst_length,
   input  logic                              req_last_burst,
   input  logic [mlfq_pkg::SLICE_W-1:0]      l1_limit,
   input  logic [mlfq_pkg::SLICE_W-1:0]      l2_limit,
   output mlfq_pkg::dp_status_type           status,
   mlfq_rsp_if.source                        rsp
);

   localparam int IDW = $clog2(NUM_TASKS);
   localparam int PW  = $clog2(MAX_BURSTS + 1);
   localparam int BAW = $clog2(NUM_TASKS * MAX_BURSTS);
   localparam int FAW = $clog2(3 * NUM_TASKS);
   localparam int FW  = $clog2(NUM_TASKS + 1);
   localparam int CW  = mlfq_pkg::CNT_W;
   localparam int LW  = mlfq_pkg::LEVEL_W;

   typedef struct packed {
      logic [PW-1:0]                  loaded;
      logic [PW-1:0]                  pos;
      logic [BURST_BITS-1:0]          tl;
      logic [LW-1:0]                  level;
      logic [mlfq_pkg::STATUS_W-1:0]  status;
      logic [CW-1:0]                  wait_cnt;
      logic [CW-1:0]                  turn_cnt;
      logic [CW-1:0]                  resp;
      logic                           seen;
   } rec_type;

   localparam rec_type REC_RST = '{loaded: '0, pos: '0, tl: '0,
                                   level: mlfq_pkg::LEVEL_ONE,
                                   status: mlfq_pkg::ST_UNLOADED,
                                   wait_cnt: '0, turn_cnt: '0, resp: '0, seen: 1'b0};

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v == mlfq_pkg::CNT_SAT) ? v : v + 1'b1;
   endfunction

   function automatic logic [BAW-1:0] baddr(input logic [IDW-1:0] id, input logic [PW-1:0] p);
      return BAW'(int'(id) * MAX_BURSTS + int'(p));
   endfunction

   function automatic logic [FAW-1:0] faddr(input logic [1:0] l, input logic [IDW-1:0] p);
      return FAW'(int'(l) * NUM_TASKS + int'(p));
   endfunction

   function automatic logic [IDW-1:0] ptr_inc(input logic [IDW-1:0] p);
      return (p == IDW'(NUM_TASKS - 1)) ? '0 : p + 1'b1;
   endfunction

   // memories
   rec_type               rec_mem   [NUM_TASKS];
   logic [BURST_BITS-1:0] burst_mem [NUM_TASKS * MAX_BURSTS];
   logic [IDW-1:0]        fifo_mem  [3 * NUM_TASKS];

   logic [NUM_TASKS-1:0]  rec_vld_ff;
   rec_type               rec_q_ff, rec, upd, upd_ff, rec_wd;
   logic                  rec_vld_q_ff, rec_we;
   logic [IDW-1:0]        rd_addr, wr_addr;
   logic [BURST_BITS-1:0] burst_q_ff, burst_wd;
   logic [BAW-1:0]        b_raddr, b_waddr;
   logic                  b_we;
   logic [IDW-1:0]        fifo_q_ff;
   logic [FAW-1:0]        f_raddr;

   // level queues
   logic [IDW-1:0] head_ff [3];
   logic [IDW-1:0] tail_ff [3];
   logic [FW-1:0]  fill_ff [3];
   logic           push, pop;
   logic [1:0]     push_lvl, pop_lvl;
   logic [IDW-1:0] push_id, push_tail, pop_head;

   // latched item
   logic [IDW-1:0]        id_ff;
   logic                  id_ok_ff, last_ff;
   logic [BURST_BITS-1:0] len_ff, len_m;

   // scheduler state
   logic                    cur_valid_ff, cur_valid_in;
   logic [IDW-1:0]          cur_task_ff, cur_task_in;
   logic [mlfq_pkg::SLICE_W-1:0] slice_ff, slice_in;
   logic [CW-1:0]           tick_ff, tick_in, busy_ff, busy_in;
   logic [FW-1:0]           active_ff, active_in;
   logic                    ran_ff, ran_in;
   logic                    fin_v_ff, fin_v_in;
   logic [IDW-1:0]          fin_id_ff, fin_id_in;
   logic [CW-1:0]           fin_wait_ff, fin_wait_in, fin_turn_ff, fin_turn_in;
   logic [CW-1:0]           fin_resp_ff, fin_resp_in;
   logic                    need_burst, any_queued, out_free, limit_hit, preempt;
   logic                    out_load;

   assign rec        = rec_vld_q_ff ? rec_q_ff : REC_RST;
   assign any_queued = (fill_ff[0] != '0) || (fill_ff[1] != '0) || (fill_ff[2] != '0);
   assign out_free   = !rsp.valid || rsp.ready;
   assign out_load   = (op == mlfq_pkg::OP_FIN) && out_free;
   assign len_m      = BURST_BITS'(req_burst_length);

   assign pop_lvl   = (fill_ff[0] != '0) ? 2'd0 : ((fill_ff[1] != '0) ? 2'd1 : 2'd2);
   assign pop_head  = head_ff[pop_lvl];
   assign push_tail = tail_ff[push_lvl];
   assign f_raddr   = faddr(pop_lvl, pop_head);

   assign limit_hit = (rec.level == mlfq_pkg::LEVEL_ONE && slice_ff == l1_limit) ||
                      (rec.level == mlfq_pkg::LEVEL_TWO && slice_ff == l2_limit);
   assign preempt   = (rec.level == mlfq_pkg::LEVEL_TWO && fill_ff[0] != '0) ||
                      (rec.level == mlfq_pkg::LEVEL_THREE &&
                       (fill_ff[0] != '0 || fill_ff[1] != '0));

   assign status.cur_valid  = cur_valid_ff;
   assign status.any_queued = any_queued;
   assign status.need_burst = need_burst;
   assign status.out_free   = out_free;

   always_comb begin
      rd_addr      = sweep_idx;
      wr_addr      = sweep_idx;
      rec_we       = 1'b0;
      upd          = rec;
      rec_wd       = rec;
      b_raddr      = '0;
      b_waddr      = '0;
      b_we         = 1'b0;
      burst_wd     = len_ff;
      push         = 1'b0;
      push_lvl     = 2'd0;
      push_id      = '0;
      pop          = 1'b0;
      need_burst   = 1'b0;
      cur_valid_in = cur_valid_ff;
      cur_task_in  = cur_task_ff;
      slice_in     = slice_ff;
      tick_in      = tick_ff;
      busy_in      = busy_ff;
      active_in    = active_ff;
      ran_in       = ran_ff;
      fin_v_in     = fin_v_ff;
      fin_id_in    = fin_id_ff;
      fin_wait_in  = fin_wait_ff;
      fin_turn_in  = fin_turn_ff;
      fin_resp_in  = fin_resp_ff;
      unique case (op)
         mlfq_pkg::OP_ACCEPT: begin
            if (req_action) begin
               ran_in      = 1'b0;
               fin_v_in    = 1'b0;
               fin_id_in   = '0;
               fin_wait_in = '0;
               fin_turn_in = '0;
               fin_resp_in = '0;
               if (!cur_valid_ff) slice_in = '0;
            end
         end
         mlfq_pkg::OP_LD_RD: begin
            rd_addr = id_ff;
            b_raddr = baddr(id_ff, '0);
         end
         mlfq_pkg::OP_LD_WR: begin
            wr_addr = id_ff;
            if (id_ok_ff && rec.status == mlfq_pkg::ST_UNLOADED) begin
               if (rec.loaded < PW'(MAX_BURSTS)) begin
                  b_we       = 1'b1;
                  b_waddr    = baddr(id_ff, rec.loaded);
                  upd.loaded = rec.loaded + 1'b1;
               end
               if (last_ff) begin
                  upd.pos    = '0;
                  // first burst may be the one stored this cycle
                  upd.tl     = (rec.loaded == '0) ? len_ff : burst_q_ff;
                  upd.level  = mlfq_pkg::LEVEL_ONE;
                  upd.status = mlfq_pkg::ST_READY;
                  push       = 1'b1;
                  push_lvl   = 2'd0;
                  push_id    = id_ff;
                  active_in  = active_ff + 1'b1;
               end
               rec_we = 1'b1;
               rec_wd = upd;
            end
         end
         mlfq_pkg::OP_DP_POP: begin
            pop = any_queued;
         end
         mlfq_pkg::OP_DP_RD: begin
            rd_addr = fifo_q_ff;
         end
         mlfq_pkg::OP_DP_WR: begin
            wr_addr = fifo_q_ff;
            if (!rec.seen) begin
               upd.resp = rec.wait_cnt;
               upd.seen = 1'b1;
            end
            upd.status   = mlfq_pkg::ST_RUN;
            rec_we       = 1'b1;
            rec_wd       = upd;
            cur_task_in  = fifo_q_ff;
            cur_valid_in = 1'b1;
         end
         mlfq_pkg::OP_SW_UP: begin
            if (rec.status == mlfq_pkg::ST_READY) begin
               upd.wait_cnt = sat_inc(rec.wait_cnt);
               upd.turn_cnt = sat_inc(rec.turn_cnt);
               rec_we       = 1'b1;
            end else if (rec.status == mlfq_pkg::ST_IO) begin
               upd.tl       = rec.tl - 1'b1;
               upd.turn_cnt = sat_inc(rec.turn_cnt);
               rec_we       = 1'b1;
               if (upd.tl == '0) begin
                  upd.pos    = rec.pos + 1'b1;
                  upd.status = mlfq_pkg::ST_READY;
                  need_burst = 1'b1;
                  b_raddr    = baddr(sweep_idx, upd.pos);
               end
            end
            rec_wd = upd;
         end
         mlfq_pkg::OP_SW_IO: begin
            upd      = upd_ff;
            upd.tl   = burst_q_ff;
            rec_we   = 1'b1;
            rec_wd   = upd;
            push     = 1'b1;
            push_lvl = upd_ff.level - 1'b1;
            push_id  = sweep_idx;
         end
         mlfq_pkg::OP_RN_RD: begin
            rd_addr = cur_task_ff;
            ran_in  = 1'b1;
         end
         mlfq_pkg::OP_RN_UP: begin
            wr_addr      = cur_task_ff;
            busy_in      = sat_inc(busy_ff);
            upd.tl       = rec.tl - 1'b1;
            upd.turn_cnt = sat_inc(rec.turn_cnt);
            if (upd.tl == '0) begin
               cur_valid_in = 1'b0;
               if (({1'b0, rec.pos} + (PW+1)'(2)) >= {1'b0, rec.loaded}) begin
                  upd.status  = mlfq_pkg::ST_DONE;
                  fin_v_in    = 1'b1;
                  fin_id_in   = cur_task_ff;
                  fin_wait_in = upd.wait_cnt;
                  fin_turn_in = upd.turn_cnt;
                  fin_resp_in = upd.resp;
                  active_in   = active_ff - 1'b1;
               end else begin
                  upd.pos    = rec.pos + 1'b1;
                  need_burst = 1'b1;
                  b_raddr    = baddr(cur_task_ff, upd.pos);
               end
            end else if (limit_hit || preempt) begin
               if (limit_hit && rec.level != mlfq_pkg::LEVEL_THREE) upd.level = rec.level + 1'b1;
               upd.status   = mlfq_pkg::ST_READY;
               cur_valid_in = 1'b0;
               push         = 1'b1;
               push_lvl     = upd.level - 1'b1;
               push_id      = cur_task_ff;
            end
            rec_we = 1'b1;
            rec_wd = upd;
         end
         mlfq_pkg::OP_RN_IO: begin
            wr_addr    = cur_task_ff;
            upd        = upd_ff;
            upd.tl     = burst_q_ff;
            upd.status = mlfq_pkg::ST_IO;
            rec_we     = 1'b1;
            rec_wd     = upd;
         end
         mlfq_pkg::OP_FIN: begin
            if (out_free) begin
               tick_in  = sat_inc(tick_ff);
               slice_in = slice_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (rec_we) rec_mem[wr_addr] <= rec_wd;
      rec_q_ff     <= rec_mem[rd_addr];
      rec_vld_q_ff <= rec_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) burst_mem[b_waddr] <= burst_wd;
      burst_q_ff <= burst_mem[b_raddr];
   end

   // hold the popped id through the dispatch steps
   always_ff @(posedge clock) begin
      if (push) fifo_mem[faddr(push_lvl, push_tail)] <= push_id;
      if (op == mlfq_pkg::OP_DP_POP) fifo_q_ff <= fifo_mem[f_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_vld_ff <= '0;
      end else if (rec_we) begin
         rec_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 3; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
      end else begin
         for (int l = 0; l < 3; l++) begin
            if (push && push_lvl == 2'(l) && fill_ff[l] < FW'(NUM_TASKS)) begin
               tail_ff[l] <= ptr_inc(tail_ff[l]);
               fill_ff[l] <= fill_ff[l] + 1'b1;
            end else if (pop && pop_lvl == 2'(l)) begin
               head_ff[l] <= ptr_inc(head_ff[l]);
               fill_ff[l] <= fill_ff[l] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op == mlfq_pkg::OP_ACCEPT) begin
         id_ff    <= IDW'(req_task_id);
         id_ok_ff <= (32'(req_task_id) < 32'(NUM_TASKS));
         len_ff   <= (len_m == '0) ? BURST_BITS'(1) : len_m;
         last_ff  <= req_last_burst;
      end
      upd_ff      <= upd;
      fin_id_ff   <= fin_id_in;
      fin_wait_ff <= fin_wait_in;
      fin_turn_ff <= fin_turn_in;
      fin_resp_ff <= fin_resp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_task_ff  <= '0;
         slice_ff     <= '0;
         tick_ff      <= '0;
         busy_ff      <= '0;
         active_ff    <= '0;
         ran_ff       <= 1'b0;
         fin_v_ff     <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_task_ff  <= cur_task_in;
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
         busy_ff      <= busy_in;
         active_ff    <= active_in;
         ran_ff       <= ran_in;
         fin_v_ff     <= fin_v_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp.valid <= 1'b0;
      end else if (out_load) begin
         rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
         rsp.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp.running_task        <= ran_ff ? mlfq_pkg::TASK_ID_W'(cur_task_ff) : '0;
         rsp.cpu_idle            <= !ran_ff;
         rsp.finished_valid      <= fin_v_ff;
         rsp.finished_task       <= mlfq_pkg::TASK_ID_W'(fin_id_ff);
         rsp.finished_wait       <= fin_wait_ff;
         rsp.finished_turnaround <= fin_turn_ff;
         rsp.finished_response   <= fin_resp_ff;
         rsp.elapsed_ticks       <= tick_in;
         rsp.busy_ticks          <= busy_ff;
         rsp.all_done            <= (active_ff == '0);
      end
   end

endmodule

@@ src/multilevel_feedback_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Three-level feedback-queue CPU scheduler stepped by load and tick items.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            carries
//   req_chan  in         valid/ready          action, task_id, burst_length, last_burst
//   rsp_chan  out        valid/ready          one result per tick item
//   csr_*     in         APB psel/penable     level1/level2 slice limits
//
// A load item reads and then writes the task record. A tick item is accepted,
// dispatches a queued task if none runs, sweeps the task record memory task
// by task, updates the running task if there is one, and posts the result.
// Reset clears control state and the record valid bits.
// A finished result waits in the output register; loads go on meanwhile and
// the next tick holds in its last step until that result is taken.
//
module multilevel_feedback_queue_scheduler #(
   parameter int NUM_TASKS  = mlfq_pkg::NUM_TASKS_DEF,
   parameter int MAX_BURSTS = mlfq_pkg::MAX_BURSTS_DEF,
   parameter int BURST_BITS = mlfq_pkg::BURST_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   mlfq_req_if.sink                        req_chan,
   mlfq_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mlfq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mlfq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mlfq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [mlfq_pkg::SLICE_W-1:0] l1_limit, l2_limit;
   mlfq_pkg::op_type             op;
   mlfq_pkg::dp_status_type      status;
   logic [$clog2(NUM_TASKS)-1:0] sweep_idx;

   // slice limit registers
   mlfq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .l1_limit    (l1_limit),
      .l2_limit    (l2_limit)
   );

   // sequencer: accept only when idle, then walk the load or tick phases
   mlfq_ctrl #(.NUM_TASKS(NUM_TASKS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .status     (status),
      .op         (op),
      .sweep_idx  (sweep_idx)
   );

   // records, bursts, level queues, totals and the result register
   mlfq_dp #(
      .NUM_TASKS  (NUM_TASKS),
      .MAX_BURSTS (MAX_BURSTS),
      .BURST_BITS (BURST_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .sweep_idx        (sweep_idx),
      .req_action       (req_chan.action),
      .req_task_id      (req_chan.task_id),
      .req_burst_length (req_chan.burst_length),
      .req_last_burst   (req_chan.last_burst),
      .l1_limit         (l1_limit),
      .l2_limit         (l2_limit),
      .status           (status),
      .rsp              (rsp_chan)
   );

endmodule

@@ src/mlfq_checker.sv @@
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks on the scheduler's result channel, bound to the top.
// ----------------------------------------------------------------------------
module mlfq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mlfq_pkg::TASK_ID_W-1:0] running_task,
   input logic                           cpu_idle,
   input logic                           finished_valid,
   input logic [mlfq_pkg::TASK_ID_W-1:0] finished_task,
   input logic [mlfq_pkg::CNT_W-1:0]     finished_wait,
   input logic [mlfq_pkg::CNT_W-1:0]     finished_turnaround,
   input logic [mlfq_pkg::CNT_W-1:0]     finished_response,
   input logic [mlfq_pkg::CNT_W-1:0]     elapsed_ticks,
   input logic [mlfq_pkg::CNT_W-1:0]     busy_ticks
);

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(elapsed_ticks))
      else $error("result dropped or changed while stalled");

   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cpu_idle |-> running_task == '0)
      else $error("idle tick reports a running task");

   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !finished_valid |-> finished_task == '0 && finished_wait == '0 &&
         finished_turnaround == '0 && finished_response == '0)
      else $error("finish fields set without a finished task");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ticks <= elapsed_ticks && elapsed_ticks != '0)
      else $error("busy ticks exceed elapsed ticks");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .running_task        (rsp_chan.running_task),
   .cpu_idle            (rsp_chan.cpu_idle),
   .finished_valid      (rsp_chan.finished_valid),
   .finished_task       (rsp_chan.finished_task),
   .finished_wait       (rsp_chan.finished_wait),
   .finished_turnaround (rsp_chan.finished_turnaround),
   .finished_response   (rsp_chan.finished_response),
   .elapsed_ticks       (rsp_chan.elapsed_ticks),
   .busy_ticks          (rsp_chan.busy_ticks)
);
